// File: hdl/med5cf_pkg.sv
// Shared types and constants of the four-channel median-of-5 filter.
package med5cf_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int CHANNELS    = 4;
	localparam int DEPTH       = 5;
	localparam int QCH_BITS    = 3;
	localparam int CH_IDX_BITS = $clog2(CHANNELS);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CHANNELS-1:0]    flags_t;
	typedef logic [QCH_BITS-1:0]    qch_t;

	// item kinds
	localparam logic MODE_CONV  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// per-channel step control from the top level
	typedef struct packed {
		logic conv;   // a conversion beat is processed this cycle
		logic prime;  // first conversion since reset
	} chan_ctl_t;

endpackage

// File: hdl/med5cf_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface med5cf_in_if;
	logic                 valid;
	logic                 ready;
	logic                 mode;
	med5cf_pkg::sample_t  sample_v;
	med5cf_pkg::sample_t  sample_x;
	med5cf_pkg::sample_t  sample_y;
	med5cf_pkg::sample_t  sample_u;
	med5cf_pkg::qch_t     query_channel;

	modport source (output valid, mode, sample_v, sample_x, sample_y, sample_u,
		query_channel, input ready);
	modport sink (input valid, mode, sample_v, sample_x, sample_y, sample_u,
		query_channel, output ready);
endinterface

interface med5cf_out_if;
	logic                 valid;
	logic                 ready;
	med5cf_pkg::sample_t  filtered_v;
	med5cf_pkg::sample_t  filtered_x;
	med5cf_pkg::sample_t  filtered_y;
	med5cf_pkg::sample_t  filtered_u;
	med5cf_pkg::flags_t   change_flags;
	logic                 was_changed;

	modport source (output valid, filtered_v, filtered_x, filtered_y, filtered_u,
		change_flags, was_changed, input ready);
	modport sink (input valid, filtered_v, filtered_x, filtered_y, filtered_u,
		change_flags, was_changed, output ready);
endinterface

// File: hdl/median5_filter_change_flags.sv
// Top level: input register, four filter channels, flag logic, result register.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  din     | in  | mode, sample_v/x/y/u, query_channel
//  dout    | out | filtered_v/x/y/u, change_flags, was_changed
//
// One beat per cycle sustained while dout is ready; a beat's result passes
// through the input register, then the median network and flag update into the
// result register. The median network per channel sits between the history
// registers and the result register.
// Reset clears the flags, the filtered values and the primed state.
// A stalled result holds; an empty input register still fills while the result waits.
module median5_filter_change_flags (
	input  logic        clk,
	input  logic        arst_n,
	med5cf_in_if.sink   din,
	med5cf_out_if.source dout
);

	// input register
	logic                  v_s1;
	logic                  mode_s1;
	med5cf_pkg::sample_t   samp_s1 [med5cf_pkg::CHANNELS];
	med5cf_pkg::qch_t      qch_s1;

	logic                  adv;
	logic                  process;
	logic                  primed_q;
	med5cf_pkg::flags_t    flags_q;
	med5cf_pkg::flags_t    flags_nx;
	med5cf_pkg::flags_t    chg;
	logic                  was_nx;
	med5cf_pkg::chan_ctl_t ctl;
	med5cf_pkg::sample_t   filt_nx [med5cf_pkg::CHANNELS];

	// result register
	logic                  res_v_q;
	med5cf_pkg::sample_t   res_filt_q [med5cf_pkg::CHANNELS];
	med5cf_pkg::flags_t    res_flags_q;
	logic                  res_was_q;

	assign adv       = !res_v_q || dout.ready;
	assign process   = v_s1 && adv;
	assign din.ready = !v_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			mode_s1    <= din.mode;
			samp_s1[0] <= din.sample_v;
			samp_s1[1] <= din.sample_x;
			samp_s1[2] <= din.sample_y;
			samp_s1[3] <= din.sample_u;
			qch_s1     <= din.query_channel;
		end
	end

	assign ctl.conv  = process && (mode_s1 == med5cf_pkg::MODE_CONV);
	assign ctl.prime = !primed_q;

	// channels
	for (genvar c = 0; c < med5cf_pkg::CHANNELS; c++) begin : g_chan
		med5cf_chan u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sample  (samp_s1[c]),
			.filt_nx (filt_nx[c]),
			.changed (chg[c])
		);
	end

	// sticky flags: set on change (all set by the first conversion), read and cleared by a query of channel 0 to 3
	always_comb begin
		flags_nx = flags_q;
		was_nx   = 1'b0;
		if (ctl.conv) begin
			flags_nx = ctl.prime ? '1 : (flags_q | chg);
		end else if (process && qch_s1 < med5cf_pkg::qch_t'(med5cf_pkg::CHANNELS)) begin
			was_nx = flags_q[qch_s1[med5cf_pkg::CH_IDX_BITS-1:0]];
			flags_nx[qch_s1[med5cf_pkg::CH_IDX_BITS-1:0]] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			primed_q <= 1'b0;
		end else begin
			flags_q <= flags_nx;
			if (ctl.conv) begin
				primed_q <= 1'b1;
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			res_filt_q  <= filt_nx;
			res_flags_q <= flags_nx;
			res_was_q   <= was_nx;
		end
	end

	assign dout.valid        = res_v_q;
	assign dout.filtered_v   = res_filt_q[0];
	assign dout.filtered_x   = res_filt_q[1];
	assign dout.filtered_y   = res_filt_q[2];
	assign dout.filtered_u   = res_filt_q[3];
	assign dout.change_flags = res_flags_q;
	assign dout.was_changed  = res_was_q;

endmodule

// File: hdl/med5cf_median.sv
// Seven-step compare-exchange network giving the median of five samples.
module med5cf_median (
	input  med5cf_pkg::sample_t a,
	input  med5cf_pkg::sample_t b,
	input  med5cf_pkg::sample_t c,
	input  med5cf_pkg::sample_t d,
	input  med5cf_pkg::sample_t e,
	output med5cf_pkg::sample_t med
);

	med5cf_pkg::sample_t a1, b1, d1, e1, d2, b2, b3, c1, c2;

	// only the network outputs that reach the middle slot are built
	always_comb begin
		a1  = (a > b) ? b : a;
		b1  = (a > b) ? a : b;
		d1  = (d > e) ? e : d;
		e1  = (d > e) ? d : e;
		d2  = (a1 > d1) ? a1 : d1;
		b2  = (b1 > e1) ? e1 : b1;
		b3  = (b2 > c) ? c : b2;
		c1  = (b2 > c) ? b2 : c;
		c2  = (c1 > d2) ? d2 : c1;
		med = (b3 > c2) ? b3 : c2;
	end

endmodule

// File: hdl/med5cf_chan.sv
// One channel: five-deep sample history, filtered value and change detect.
module med5cf_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  med5cf_pkg::chan_ctl_t ctl,
	input  med5cf_pkg::sample_t   sample,
	output med5cf_pkg::sample_t   filt_nx,
	output logic                  changed
);

	med5cf_pkg::sample_t hist_q [med5cf_pkg::DEPTH];
	med5cf_pkg::sample_t filt_q;
	med5cf_pkg::sample_t med;
	logic                diff;

	// median over the window after the new sample is shifted in
	med5cf_median u_median (
		.a   (hist_q[1]),
		.b   (hist_q[2]),
		.c   (hist_q[3]),
		.d   (hist_q[4]),
		.e   (sample),
		.med (med)
	);

	assign diff = (med != filt_q);

	// value after this step, as seen by the result register
	always_comb begin
		filt_nx = filt_q;
		if (ctl.conv) begin
			filt_nx = ctl.prime ? sample : med;
		end
	end

	assign changed = ctl.conv && !ctl.prime && diff;

	// history: fill on first conversion, shift afterward
	always_ff @(posedge clk) begin
		if (ctl.conv) begin
			for (int i = 0; i < med5cf_pkg::DEPTH - 1; i++) begin
				hist_q[i] <= ctl.prime ? sample : hist_q[i+1];
			end
			hist_q[med5cf_pkg::DEPTH-1] <= sample;
		end
	end

	// filtered value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else begin
			filt_q <= filt_nx;
		end
	end

endmodule
